### hdl/tdf_pkg.sv
// Shared constants and types for the trial division factorizer.
// No dependencies; imported by tdf_div and trial_division_factorizer.
package tdf_pkg;

    // Default width of the value to factor.
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed widths of the result fields.
    localparam int PRIME_W = 16;
    localparam int MULT_W  = 5;
    localparam int IDX_W   = 4;

    // First trial divisor.
    localparam int FIRST_DIVISOR = 2;

    // Status of the serial divider as seen by the sequencer.
    typedef struct packed {
        logic done;      // one-cycle pulse: quotient and remainder are ready
        logic rem_zero;  // remainder of the finished division is zero
    } div_status_t;

endpackage

### hdl/trial_division_factorizer.sv
// Top level of the trial division factorizer: sequencer, output register.
// Depends on tdf_pkg and tdf_div.
//
//  channel | ports                                        | role
//  --------+----------------------------------------------+-------------------------
//  input   | s_valid s_ready s_value                       | one value per beat
//  result  | m_valid m_ready m_prime_factor m_multiplicity | one prime factor per beat
//          | m_factor_index m_last m_none_flag             |
//
// Each trial division runs in the serial divider, and the sequencer then acts on
// its result. One value is worked at a time; s_ready is high only while the
// sequencer is idle. A stalled result beat holds the sequencer until m_ready,
// and the last beat may wait in the output register while the next value is
// accepted. Reset is synchronous, active low.
module trial_division_factorizer
    import tdf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PRIME_W-1:0]     m_prime_factor,
    output logic [MULT_W-1:0]      m_multiplicity,
    output logic [IDX_W-1:0]       m_factor_index,
    output logic                   m_last,
    output logic                   m_none_flag
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [MULT_W-1:0]      m_reg, m_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [PRIME_W-1:0]     pend_prime_reg, pend_prime_next;
    logic [MULT_W-1:0]      pend_mult_reg, pend_mult_next;
    logic                   pend_last_reg, pend_last_next;
    logic                   pend_none_reg, pend_none_next;

    logic                   out_valid_reg;
    logic [PRIME_W-1:0]     out_prime_reg;
    logic [MULT_W-1:0]      out_mult_reg;
    logic [IDX_W-1:0]       out_idx_reg;
    logic                   out_last_reg;
    logic                   out_none_reg;

    logic                   out_free;
    logic                   out_load;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_quo;
    div_status_t            div_st;

    tdf_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(n_next),
        .divisor (d_next),
        .quotient(div_quo),
        .status  (div_st)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Sequencer: divide, count multiplicity, step the divisor, emit factors
    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        m_next          = m_reg;
        idx_next        = idx_reg;
        pend_prime_next = pend_prime_reg;
        pend_mult_next  = pend_mult_reg;
        pend_last_next  = pend_last_reg;
        pend_none_next  = pend_none_reg;
        div_start       = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next   = s_value;
                    d_next   = VALUE_WIDTH'(FIRST_DIVISOR);
                    m_next   = '0;
                    idx_next = '0;
                    if (s_value <= VALUE_WIDTH'(1)) begin
                        pend_prime_next = '0;
                        pend_mult_next  = '0;
                        pend_last_next  = 1'b1;
                        pend_none_next  = 1'b1;
                        state_next      = ST_EMIT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    pend_none_next = 1'b0;
                    if (div_st.rem_zero) begin
                        // Divisor divides: take the quotient, count one more
                        n_next = div_quo;
                        m_next = m_reg + MULT_W'(1);
                        if (div_quo == VALUE_WIDTH'(1)) begin
                            pend_prime_next = PRIME_W'(d_reg);
                            pend_mult_next  = m_reg + MULT_W'(1);
                            pend_last_next  = 1'b1;
                            state_next      = ST_EMIT;
                        end else begin
                            div_start = 1'b1;
                        end
                    end else if (m_reg != '0) begin
                        // Divisor exhausted: report it, then retest what remains
                        pend_prime_next = PRIME_W'(d_reg);
                        pend_mult_next  = m_reg;
                        pend_last_next  = 1'b0;
                        state_next      = ST_EMIT;
                    end else if (div_quo < d_reg) begin
                        // Divisor squared exceeds the remainder: it is prime
                        pend_prime_next = PRIME_W'(n_reg);
                        pend_mult_next  = MULT_W'(1);
                        pend_last_next  = 1'b1;
                        state_next      = ST_EMIT;
                    end else begin
                        d_next    = d_reg + VALUE_WIDTH'(1);
                        div_start = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (pend_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        m_next     = '0;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg          <= n_next;
        d_reg          <= d_next;
        m_reg          <= m_next;
        idx_reg        <= idx_next;
        pend_prime_reg <= pend_prime_next;
        pend_mult_reg  <= pend_mult_next;
        pend_last_reg  <= pend_last_next;
        pend_none_reg  <= pend_none_next;
    end

    // Output register: load a pending factor, drop valid once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_prime_reg <= pend_prime_reg;
            out_mult_reg  <= pend_mult_reg;
            out_idx_reg   <= idx_reg;
            out_last_reg  <= pend_last_reg;
            out_none_reg  <= pend_none_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_prime_factor = out_prime_reg;
    assign m_multiplicity = out_mult_reg;
    assign m_factor_index = out_idx_reg;
    assign m_last         = out_last_reg;
    assign m_none_flag    = out_none_reg;

    // A no-factor beat is the only and final beat of its value
    a_none_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_none_flag) |-> (m_last && m_factor_index == '0))
        else $error("none beat not final or not first");

    // A non-final beat means the sequencer still has work for this value
    a_more_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (state_reg != ST_IDLE))
        else $error("non-final beat with sequencer idle");

    // Divider finishes only while the sequencer waits on it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // Trial divisor never drops below the first divisor while dividing
    a_divisor_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (d_reg >= VALUE_WIDTH'(FIRST_DIVISOR)))
        else $error("trial divisor below first divisor");

endmodule

### hdl/tdf_div.sv
// Radix-2 restoring divider: one quotient bit per cycle, VALUE_WIDTH steps.
// Depends on tdf_pkg for div_status_t.
module tdf_div
    import tdf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic [VALUE_WIDTH-1:0] quotient,
    output div_status_t            status
);

    localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            // Restore on borrow, keep the difference otherwise
            if (!diff[VALUE_WIDTH]) begin
                rem_next = diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = trial[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(VALUE_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient        = quo_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

    // The done flag is registered from the last step of a running division
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    // No restart while a division is running
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

    // The final remainder is below the divisor when done is flagged
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");

endmodule

### tb/sv/tb_trial_division_factorizer.sv
// Self-checking testbench for trial_division_factorizer: directed and random values
// in bursts, prime factor beats out, each checked against a trial-division predictor.
// Depends on tdf_pkg and the factorizer RTL.
`timescale 1ns / 1ps

module tb_trial_division_factorizer;
    import tdf_pkg::*;

    localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;
    localparam int unsigned VALUE_MAX = (1 << VALUE_WIDTH) - 1;
    localparam int NUM_RANDOM = 100;
    localparam int TAIL_CYCLES = 200;

    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic [MULT_W-1:0]  mult;
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic               none_flag;
    } factor_beat_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [VALUE_WIDTH-1:0] s_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [PRIME_W-1:0]     m_prime_factor;
    logic [MULT_W-1:0]      m_multiplicity;
    logic [IDX_W-1:0]       m_factor_index;
    logic                   m_last;
    logic                   m_none_flag;

    logic [VALUE_WIDTH-1:0] values_to_send[$];
    factor_beat_t           factor_expect[$];
    factor_beat_t           want;

    int total_values = 0;
    int values_sent = 0;
    int beats_checked = 0;
    int mismatch_count = 0;
    int multi_prime_values = 0;
    int no_factor_values = 0;
    int burst_left = 1;
    int gap_left = 0;

    logic [5:0] stall_phase = '0;
    logic [7:0] stall_pattern = 8'hFF;

    int unsigned small_primes[18] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37,
                                      41, 43, 47, 53, 59, 61};

    trial_division_factorizer #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prime_factor (m_prime_factor),
        .m_multiplicity (m_multiplicity),
        .m_factor_index (m_factor_index),
        .m_last         (m_last),
        .m_none_flag    (m_none_flag)
    );

    always #2 aclk = ~aclk;

    // Factor one value by trial division and queue the beats it should produce.
    // The last flag goes on the beat after which nothing is left to divide.
    task automatic queue_factorization(input logic [VALUE_WIDTH-1:0] value);
        int unsigned rest;
        int unsigned divisor;
        int unsigned mult;
        int unsigned count;
        factor_beat_t beat;
        rest = value;
        divisor = FIRST_DIVISOR;
        count = 0;
        if (rest <= 1) begin
            beat = '{prime: '0, mult: '0, idx: '0, last: 1'b1, none_flag: 1'b1};
            factor_expect.push_back(beat);
            no_factor_values++;
            return;
        end
        while (rest > 1) begin
            if (divisor * divisor > rest) begin
                // whatever survives past the square root is itself prime
                beat = '{prime: PRIME_W'(rest), mult: MULT_W'(1), idx: IDX_W'(count),
                         last: 1'b1, none_flag: 1'b0};
                factor_expect.push_back(beat);
                count++;
                rest = 1;
            end else if (rest % divisor == 0) begin
                mult = 0;
                while (rest % divisor == 0) begin
                    rest = rest / divisor;
                    mult++;
                end
                beat = '{prime: PRIME_W'(divisor), mult: MULT_W'(mult),
                         idx: IDX_W'(count), last: (rest == 1), none_flag: 1'b0};
                factor_expect.push_back(beat);
                count++;
            end
            divisor++;
        end
        if (count > 1)
            multi_prime_values++;
    endtask

    // Pick a random value, weighted toward numbers with many small factors.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        int unsigned acc;
        int unsigned p;
        int unsigned kind;
        acc = 1;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            // product of random small primes
            repeat ($urandom_range(1, 16)) begin
                p = small_primes[$urandom_range(0, 17)];
                if (acc * p <= VALUE_MAX)
                    acc = acc * p;
            end
        end else if (kind < 70) begin
            // power of a single prime
            p = small_primes[$urandom_range(0, 6)];
            repeat ($urandom_range(1, 15)) begin
                if (acc * p <= VALUE_MAX)
                    acc = acc * p;
            end
        end else if (kind < 85) begin
            acc = $urandom_range(0, VALUE_MAX);
        end else begin
            acc = $urandom_range(0, 255);
        end
        return VALUE_WIDTH'(acc);
    endfunction

    // Driver: hold the beat until taken, then launch the next in bursts with gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                queue_factorization(s_value);
                values_sent++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (values_to_send.size() > 0) begin
                    s_value <= values_to_send.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: rotate a stall pattern, pick a fresh one each time the phase counter wraps.
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 6'd1;
        if (stall_phase == '1) begin
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
        end
        m_ready <= stall_pattern[0];
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (factor_expect.size() == 0) begin
                $error("unexpected factor beat: prime_factor %0d", m_prime_factor);
                mismatch_count++;
            end else begin
                want = factor_expect.pop_front();
                beats_checked++;
                if (m_prime_factor !== want.prime) begin
                    $error("prime_factor: expected %0d, got %0d", want.prime, m_prime_factor);
                    mismatch_count++;
                end
                if (m_multiplicity !== want.mult) begin
                    $error("multiplicity: expected %0d, got %0d", want.mult, m_multiplicity);
                    mismatch_count++;
                end
                if (m_factor_index !== want.idx) begin
                    $error("factor_index: expected %0d, got %0d", want.idx, m_factor_index);
                    mismatch_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    mismatch_count++;
                end
                if (m_none_flag !== want.none_flag) begin
                    $error("none_flag: expected %0d, got %0d", want.none_flag, m_none_flag);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a run that has not finished by now is reported as a failure.
    initial begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        // zero and one, small primes, squares at the search boundary,
        // deep powers, many distinct primes and the largest inputs
        values_to_send = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9, 16'd12,
                           16'd25, 16'd49, 16'd30030, 16'd32768, 16'd59049, 16'd63001,
                           16'd65025, 16'd65521, 16'd65534, 16'd65535, 16'hAAAA,
                           16'h5555, 16'd4093, 16'd510};
        repeat (NUM_RANDOM)
            values_to_send.push_back(pick_value());
        total_values = values_to_send.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // drain: all values taken and every expected beat seen
        while (values_sent < total_values || factor_expect.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Factored %0d values into %0d checked beats.", values_sent, beats_checked);
        $display("%0d values had several distinct primes, %0d had no factors.",
                 multi_prime_values, no_factor_values);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
